@@ src/pom_pkg.sv @@
package pom_pkg;

  // Field widths
  localparam int RES_W   = 13;
  localparam int STEP_W  = 10;
  localparam int VOLT_W  = 15;
  localparam int PWR_W   = 14;
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [RES_W-1:0]  MIN_RES_RST   = 13'd0;
  localparam logic [RES_W-1:0]  MAX_RES_RST   = 13'd5000;
  localparam logic [RES_W-1:0]  START_RES_RST = 13'd2500;
  localparam logic [STEP_W-1:0] STEP_RST      = 10'd50;
  localparam logic [VOLT_W-1:0] MIN_VOLT_RST  = 15'd1000;
  localparam logic [TICK_W-1:0] INTERVAL_RST  = 16'd500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RES   = 3'd0,
    REG_MAX_RES   = 3'd1,
    REG_START_RES = 3'd2,
    REG_STEP      = 3'd3,
    REG_MIN_VOLT  = 3'd4,
    REG_INTERVAL  = 3'd5
  } cfg_reg_t;

  // Current configuration, as seen by the tracker core
  typedef struct packed {
    logic [RES_W-1:0]  min_res;
    logic [RES_W-1:0]  max_res;
    logic [RES_W-1:0]  start_res;
    logic [STEP_W-1:0] step;
    logic [VOLT_W-1:0] min_volt;
    logic [TICK_W-1:0] interval;
  } cfg_t;

  // Request payloads
  typedef struct packed {
    logic [VOLT_W-1:0] panel_voltage;
    logic [PWR_W-1:0]  panel_power;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] load_resistance;
    logic             moving_up;
    logic             low_voltage;
  } out_item_t;

endpackage

@@ src/pom_cfg.sv @@
module pom_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pom_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pom_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pom_pkg::cfg_t                   cfg,
  output logic                            start_load,
  output logic [pom_pkg::RES_W-1:0]       start_value
);
  import pom_pkg::*;

  cfg_t cfg_r;

  // Register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_res   <= MIN_RES_RST;
      cfg_r.max_res   <= MAX_RES_RST;
      cfg_r.start_res <= START_RES_RST;
      cfg_r.step      <= STEP_RST;
      cfg_r.min_volt  <= MIN_VOLT_RST;
      cfg_r.interval  <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_RES:   cfg_r.min_res   <= cfg_data[RES_W-1:0];
        REG_MAX_RES:   cfg_r.max_res   <= cfg_data[RES_W-1:0];
        REG_START_RES: cfg_r.start_res <= cfg_data[RES_W-1:0];
        REG_STEP:      cfg_r.step      <= cfg_data[STEP_W-1:0];
        REG_MIN_VOLT:  cfg_r.min_volt  <= cfg_data[VOLT_W-1:0];
        REG_INTERVAL:  cfg_r.interval  <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
  // Writing the start value also presets the live resistance, with the new value
  assign start_load  = cfg_we && (cfg_reg_t'(cfg_index) == REG_START_RES);
  assign start_value = cfg_data[RES_W-1:0];

endmodule

@@ src/pom_core.sv @@
module pom_core #(
  parameter int RESISTANCE_FULL_SCALE = 5000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pom_pkg::cfg_t                 cfg,
  input  logic                          start_load,
  input  logic [pom_pkg::RES_W-1:0]     start_value,
  input  logic                          advance,
  input  pom_pkg::in_item_t             item,
  output logic                          res_valid,
  output pom_pkg::out_item_t            res
);
  import pom_pkg::*;

  localparam logic [31:0] FULL_SCALE = RESISTANCE_FULL_SCALE;

  // Tracker state
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [PWR_W-1:0]  prev_pwr_r, prev_pwr_nxt;
  logic [RES_W-1:0]  res_now_r, res_now_nxt;
  logic              dir_up_r, dir_up_nxt;
  logic              baseline_r, baseline_nxt;

  logic [TICK_W-1:0]       tick_inc;
  logic                    update;
  logic                    low_v;
  logic                    dir_new;
  logic [RES_W-1:0]        hi_lim;
  logic signed [RES_W+1:0] r_base, r_step, r_sum, lo_s, hi_s;
  logic [RES_W-1:0]        r_clamped;

  // Tick count, saturating
  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 1'b1;
  assign update   = (tick_inc >= cfg.interval);

  // Perturbation: undervoltage steps up, otherwise reverse on a power drop
  assign low_v   = (item.panel_voltage < cfg.min_volt);
  assign dir_new = low_v ? dir_up_r : (dir_up_r ^ (item.panel_power < prev_pwr_r));
  assign r_base  = {2'b00, res_now_r};
  assign r_step  = {{(RES_W+2-STEP_W){1'b0}}, cfg.step};
  assign r_sum   = (low_v || dir_new) ? (r_base + r_step) : (r_base - r_step);

  // Clamp: lower limit checked first, upper limit is max_res capped at full scale
  assign hi_lim = ({{(32-RES_W){1'b0}}, cfg.max_res} > FULL_SCALE) ?
                  FULL_SCALE[RES_W-1:0] : cfg.max_res;
  assign lo_s   = {2'b00, cfg.min_res};
  assign hi_s   = {2'b00, hi_lim};

  always_comb begin
    priority if (r_sum < lo_s) begin
      r_clamped = cfg.min_res;
    end else if (r_sum > hi_s) begin
      r_clamped = hi_lim;
    end else begin
      r_clamped = r_sum[RES_W-1:0];
    end
  end

  // Next state and result
  always_comb begin
    tick_nxt     = tick_r;
    prev_pwr_nxt = prev_pwr_r;
    res_now_nxt  = res_now_r;
    dir_up_nxt   = dir_up_r;
    baseline_nxt = baseline_r;
    res_valid    = 1'b0;
    res.load_resistance = r_clamped;
    res.moving_up       = dir_new;
    res.low_voltage     = low_v;
    if (advance) begin
      if (!update) begin
        tick_nxt = tick_inc;
      end else begin
        tick_nxt     = '0;
        prev_pwr_nxt = item.panel_power;
        baseline_nxt = 1'b0;
        if (!baseline_r) begin
          res_now_nxt = r_clamped;
          dir_up_nxt  = dir_new;
          res_valid   = 1'b1;
        end
      end
    end
    if (start_load) begin
      res_now_nxt = start_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      prev_pwr_r <= '0;
      res_now_r  <= START_RES_RST;
      dir_up_r   <= 1'b0;
      baseline_r <= 1'b1;
    end else begin
      tick_r     <= tick_nxt;
      prev_pwr_r <= prev_pwr_nxt;
      res_now_r  <= res_now_nxt;
      dir_up_r   <= dir_up_nxt;
      baseline_r <= baseline_nxt;
    end
  end

  // The baseline update never emits
  a_baseline_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && baseline_r) |-> !res_valid)
    else $error("result emitted on baseline update");

  // Emitted resistance sits inside ordered limits
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (cfg.min_res <= hi_lim)) |->
      (res.load_resistance >= cfg.min_res && res.load_resistance <= hi_lim))
    else $error("resistance outside clamp limits");

  // An update restarts the tick count
  a_tick_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (tick_r == '0))
    else $error("tick count not restarted after update");

endmodule

@@ src/perturb_observe_mppt.sv @@
// Perturb-and-observe maximum power point tracker.
// in_*  : one request per millisecond tick carrying panel voltage (mV) and
//         power (mW). Every request counts a tick; once update_interval ticks
//         have passed an update runs. The first update after reset only
//         records baseline power and returns nothing.
// out_* : one request per update with the new clamped load resistance
//         (ohms), the stored direction and the undervoltage flag.
// cfg_* : write-only register port, one write per cycle, no wait states.
//         Writing start_resistance also presets the live resistance.
// An accepted request passes the input register, then the result register.
//   Throughput: one request per cycle while the result slot is free or taken;
//   the whole update is one compare/add/clamp pass between the two registers.
// Reset (synchronous, active low) empties both registers and restores the
//   default configuration and tracker state.
// When the receiver stalls the result register holds; the input register
//   still absorbs one request, then in_ready drops until the result is taken.
module perturb_observe_mppt #(
  parameter int RESISTANCE_FULL_SCALE = 5000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pom_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pom_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [pom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pom_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pom_pkg::*;

  cfg_t             cfg;
  logic             start_load;
  logic [RES_W-1:0] start_value;
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             advance;
  logic             res_valid;
  out_item_t        res;

  pom_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .start_load  (start_load),
    .start_value (start_value)
  );

  // Stage handshake: the held request moves on when the result slot is free
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  pom_core #(
    .RESISTANCE_FULL_SCALE (RESISTANCE_FULL_SCALE)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .start_load  (start_load),
    .start_value (start_value),
    .advance     (advance),
    .item        (s1_item_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A held request is not dropped while the result slot is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost a stalled request");

  // A new result never overwrites one that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule
